[sv/hrd_pkg.sv]
// shared types, item prefixes and helpers for the hid report descriptor parser
// no dependencies

package hrd_pkg;

    localparam logic [7:0] TAG_MASK          = 8'hFC;
    localparam logic [7:0] ITEM_INPUT        = 8'h80;
    localparam logic [7:0] ITEM_OUTPUT       = 8'h90;
    localparam logic [7:0] ITEM_COLLECTION   = 8'hA0;
    localparam logic [7:0] ITEM_FEATURE      = 8'hB0;
    localparam logic [7:0] ITEM_END_COLL     = 8'hC0;
    localparam logic [7:0] ITEM_USAGE_PAGE   = 8'h04;
    localparam logic [7:0] ITEM_LOGICAL_MIN  = 8'h14;
    localparam logic [7:0] ITEM_LOGICAL_MAX  = 8'h24;
    localparam logic [7:0] ITEM_REPORT_SIZE  = 8'h74;
    localparam logic [7:0] ITEM_REPORT_ID    = 8'h84;
    localparam logic [7:0] ITEM_REPORT_COUNT = 8'h94;
    localparam logic [7:0] ITEM_USAGE        = 8'h08;
    localparam logic [7:0] ITEM_USAGE_MIN    = 8'h18;
    localparam logic [7:0] ITEM_USAGE_MAX    = 8'h28;

    localparam logic [1:0] SIZE_NONE = 2'd0;
    localparam logic [1:0] SIZE_FOUR = 2'd3;

    localparam logic [7:0]  DEPTH_MAX = 8'hFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        KIND_INPUT,
        KIND_OUTPUT,
        KIND_FEATURE,
        KIND_COLLECTION,
        KIND_END_COLLECTION
    } hrd_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_IMBALANCE,
        STATUS_TRUNCATED
    } hrd_status_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } hrd_byte_t;

    typedef struct packed {
        hrd_kind_t   kind;
        logic [31:0] item_value;
        logic [31:0] usage_page;
        logic [31:0] logical_min;
        logic [31:0] logical_max;
        logic [31:0] report_size;
        logic [31:0] report_count;
        logic [31:0] report_id;
        logic [31:0] first_usage;
        logic [15:0] usage_count;
        logic [7:0]  nest_depth;
        hrd_status_t status;
    } hrd_result_t;

    // data bytes that follow a short item prefix
    function automatic logic [2:0] data_len(input logic [1:0] size_code);
        logic [2:0] len;
        case (size_code)
            2'd0: len = 3'd0;
            2'd1: len = 3'd1;
            2'd2: len = 3'd2;
            2'd3: len = 3'd4;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

endpackage

[sv/hid_report_descriptor_parser.sv]
// top level of the hid report descriptor parser: stream ports and result register
// depends on hrd_pkg, hrd_in_stage and hrd_core

// Takes a HID report descriptor one byte per transfer, with s_tlast on its final byte,
// and returns one result for each Input, Output, Feature, Collection or End Collection
// item, for an unbalanced End Collection, and for an item cut short by the last byte;
// after an unbalanced End Collection no later item gives a result until the last byte.
// A byte is taken every cycle as long as results are taken. A byte waits in the input
// register while the item decode and state update form its result, which the result
// register then holds. After the last byte all tracked state returns to its reset value.

module hid_report_descriptor_parser
    import hrd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata,   // item_value, usage_page, logical_min, logical_max,
                                    // report_size, report_count, report_id, first_usage,
                                    // usage_count, nest_depth, status, zero fill
    output logic [2:0]   m_tuser    // item_kind
);

    logic        held_valid;
    hrd_byte_t   held_byte;
    logic        take;
    logic        res_valid;
    hrd_result_t res;
    logic        m_tvalid_reg, m_tvalid_next;
    hrd_result_t result_reg;

    assign take = held_valid && (!m_tvalid_reg || m_tready);

    hrd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    hrd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .in_byte   (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (take) begin
            m_tvalid_next = res_valid;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && res_valid) begin
            result_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = result_reg.kind;
    assign m_tdata  = {6'd0, result_reg.status, result_reg.nest_depth,
                       result_reg.usage_count, result_reg.first_usage,
                       result_reg.report_id, result_reg.report_count,
                       result_reg.report_size, result_reg.logical_max,
                       result_reg.logical_min, result_reg.usage_page,
                       result_reg.item_value};

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |-> !take)
        else $error("pending result overwritten");

    a_truncated_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && result_reg.status == STATUS_TRUNCATED |->
            result_reg.kind == KIND_INPUT && result_reg.item_value == 32'd0)
        else $error("bad truncated result");

    a_result_follows_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(take) && $past(res_valid))
        else $error("result without processed byte");

endmodule

[sv/hrd_in_stage.sv]
// input register for descriptor bytes
// depends on hrd_pkg

module hrd_in_stage
    import hrd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic [7:0] s_tdata,
    input  logic      s_tlast,
    input  logic      take,
    output logic      held_valid,
    output hrd_byte_t held_byte
);

    logic      valid_reg;
    logic      valid_next;
    hrd_byte_t byte_reg;

    assign s_tready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= '{data: s_tdata, last: s_tlast};
        end
    end

endmodule

[sv/hrd_core.sv]
// item assembly, global and local state tracking and result formation
// depends on hrd_pkg

module hrd_core
    import hrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        take,
    input  hrd_byte_t   in_byte,
    output logic        res_valid,
    output hrd_result_t res
);

    logic [2:0]  phase_reg, phase_next, phase_upd;
    logic [7:0]  prefix_reg, prefix_next, prefix_upd;
    logic [31:0] acc_reg, acc_next, acc_upd;
    logic [31:0] page_reg, page_next, page_upd;
    logic [31:0] lmin_reg, lmin_next, lmin_upd;
    logic [31:0] lmax_reg, lmax_next, lmax_upd;
    logic [31:0] rsize_reg, rsize_next, rsize_upd;
    logic [31:0] rcount_reg, rcount_next, rcount_upd;
    logic [31:0] rid_reg, rid_next, rid_upd;
    logic [31:0] range_reg, range_next, range_upd;
    logic [31:0] ufirst_reg, ufirst_next, ufirst_upd;
    logic [15:0] ucnt_reg, ucnt_next, ucnt_upd;
    logic [7:0]  depth_reg, depth_next, depth_upd;
    logic        halted_reg, halted_next, halted_upd;

    logic [1:0]  phase_idx;
    logic [31:0] acc_merge;
    logic        item_done;
    logic [7:0]  item_prefix;
    logic [31:0] item_val;
    logic [31:0] uval;
    logic [31:0] span;
    logic [16:0] range_sum;
    logic        main_item;
    hrd_kind_t   kind;
    hrd_status_t status;

    assign phase_idx = 2'(phase_reg - 3'd1);
    assign acc_merge = acc_reg | ({24'd0, in_byte.data} << {phase_idx, 3'b000});
    assign uval      = (item_prefix[1:0] != SIZE_FOUR) ? (item_val | page_reg) : item_val;
    assign span      = uval - range_reg;
    assign range_sum = {1'b0, ucnt_reg} + {1'b0, span[15:0]} + 17'd1;

    always_comb begin
        phase_upd   = phase_reg;
        prefix_upd  = prefix_reg;
        acc_upd     = acc_reg;
        page_upd    = page_reg;
        lmin_upd    = lmin_reg;
        lmax_upd    = lmax_reg;
        rsize_upd   = rsize_reg;
        rcount_upd  = rcount_reg;
        rid_upd     = rid_reg;
        range_upd   = range_reg;
        ufirst_upd  = ufirst_reg;
        ucnt_upd    = ucnt_reg;
        depth_upd   = depth_reg;
        halted_upd  = halted_reg;
        item_done   = 1'b0;
        item_prefix = in_byte.data;
        item_val    = '0;
        main_item   = 1'b0;
        kind        = KIND_INPUT;
        status      = STATUS_OK;
        res_valid   = 1'b0;

        if (!halted_reg) begin
            if (phase_reg == 3'd0) begin
                if (in_byte.data[1:0] == SIZE_NONE) begin
                    item_done = 1'b1;
                end else begin
                    prefix_upd = in_byte.data;
                    acc_upd    = '0;
                    phase_upd  = 3'd1;
                end
            end else begin
                acc_upd = acc_merge;
                if (phase_reg >= data_len(prefix_reg[1:0])) begin
                    phase_upd   = 3'd0;
                    item_done   = 1'b1;
                    item_prefix = prefix_reg;
                    item_val    = acc_merge;
                end else begin
                    phase_upd = phase_reg + 3'd1;
                end
            end

            if (item_done) begin
                case (item_prefix & TAG_MASK)
                    ITEM_INPUT: begin
                        main_item = 1'b1;
                        kind      = KIND_INPUT;
                    end
                    ITEM_OUTPUT: begin
                        main_item = 1'b1;
                        kind      = KIND_OUTPUT;
                    end
                    ITEM_FEATURE: begin
                        main_item = 1'b1;
                        kind      = KIND_FEATURE;
                    end
                    ITEM_COLLECTION: begin
                        main_item = 1'b1;
                        kind      = KIND_COLLECTION;
                        if (depth_reg != DEPTH_MAX) begin
                            depth_upd = depth_reg + 8'd1;
                        end
                    end
                    ITEM_END_COLL: begin
                        kind      = KIND_END_COLLECTION;
                        if (depth_reg == 8'd0) begin
                            res_valid  = 1'b1;
                            status     = STATUS_IMBALANCE;
                            halted_upd = 1'b1;
                        end else begin
                            main_item = 1'b1;
                            depth_upd = depth_reg - 8'd1;
                        end
                    end
                    ITEM_USAGE_PAGE:   page_upd   = {item_val[15:0], 16'd0};
                    ITEM_LOGICAL_MIN:  lmin_upd   = item_val;
                    ITEM_LOGICAL_MAX:  lmax_upd   = item_val;
                    ITEM_REPORT_SIZE:  rsize_upd  = item_val;
                    ITEM_REPORT_ID:    rid_upd    = item_val;
                    ITEM_REPORT_COUNT: rcount_upd = item_val;
                    ITEM_USAGE: begin
                        if (ucnt_reg == 16'd0) begin
                            ufirst_upd = uval;
                        end
                        if (ucnt_reg != COUNT_MAX) begin
                            ucnt_upd = ucnt_reg + 16'd1;
                        end
                    end
                    ITEM_USAGE_MIN: range_upd = uval;
                    ITEM_USAGE_MAX: begin
                        if (uval >= range_reg) begin
                            if (ucnt_reg == 16'd0) begin
                                ufirst_upd = range_reg;
                            end
                            if (span[31:16] != 16'd0 || range_sum[16]) begin
                                ucnt_upd = COUNT_MAX;
                            end else begin
                                ucnt_upd = range_sum[15:0];
                            end
                        end
                    end
                    default: begin
                    end
                endcase

                if (main_item) begin
                    res_valid  = 1'b1;
                    ufirst_upd = '0;
                    ucnt_upd   = '0;
                    range_upd  = '0;
                end
            end

            // last byte arrives with data bytes still owed
            if (in_byte.last && phase_upd != 3'd0 && !res_valid) begin
                res_valid = 1'b1;
                kind      = KIND_INPUT;
                status    = STATUS_TRUNCATED;
            end
        end
    end

    always_comb begin
        res.kind         = kind;
        res.item_value   = (status == STATUS_TRUNCATED) ? 32'd0 : item_val;
        res.usage_page   = page_reg;
        res.logical_min  = lmin_reg;
        res.logical_max  = lmax_reg;
        res.report_size  = rsize_reg;
        res.report_count = rcount_reg;
        res.report_id    = rid_reg;
        res.first_usage  = ufirst_reg;
        res.usage_count  = ucnt_reg;
        res.nest_depth   = depth_upd;
        res.status       = status;
    end

    always_comb begin
        phase_next  = phase_reg;
        prefix_next = prefix_reg;
        acc_next    = acc_reg;
        page_next   = page_reg;
        lmin_next   = lmin_reg;
        lmax_next   = lmax_reg;
        rsize_next  = rsize_reg;
        rcount_next = rcount_reg;
        rid_next    = rid_reg;
        range_next  = range_reg;
        ufirst_next = ufirst_reg;
        ucnt_next   = ucnt_reg;
        depth_next  = depth_reg;
        halted_next = halted_reg;
        if (take) begin
            if (in_byte.last) begin
                phase_next  = '0;
                prefix_next = '0;
                acc_next    = '0;
                page_next   = '0;
                lmin_next   = '0;
                lmax_next   = '0;
                rsize_next  = '0;
                rcount_next = '0;
                rid_next    = '0;
                range_next  = '0;
                ufirst_next = '0;
                ucnt_next   = '0;
                depth_next  = '0;
                halted_next = 1'b0;
            end else begin
                phase_next  = phase_upd;
                prefix_next = prefix_upd;
                acc_next    = acc_upd;
                page_next   = page_upd;
                lmin_next   = lmin_upd;
                lmax_next   = lmax_upd;
                rsize_next  = rsize_upd;
                rcount_next = rcount_upd;
                rid_next    = rid_upd;
                range_next  = range_upd;
                ufirst_next = ufirst_upd;
                ucnt_next   = ucnt_upd;
                depth_next  = depth_upd;
                halted_next = halted_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= '0;
            prefix_reg <= '0;
            acc_reg    <= '0;
            page_reg   <= '0;
            lmin_reg   <= '0;
            lmax_reg   <= '0;
            rsize_reg  <= '0;
            rcount_reg <= '0;
            rid_reg    <= '0;
            range_reg  <= '0;
            ufirst_reg <= '0;
            ucnt_reg   <= '0;
            depth_reg  <= '0;
            halted_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
            acc_reg    <= acc_next;
            page_reg   <= page_next;
            lmin_reg   <= lmin_next;
            lmax_reg   <= lmax_next;
            rsize_reg  <= rsize_next;
            rcount_reg <= rcount_next;
            rid_reg    <= rid_next;
            range_reg  <= range_next;
            ufirst_reg <= ufirst_next;
            ucnt_reg   <= ucnt_next;
            depth_reg  <= depth_next;
            halted_reg <= halted_next;
        end
    end

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        take && in_byte.last |=> phase_reg == 3'd0 && !halted_reg && depth_reg == 8'd0)
        else $error("state not cleared after last byte");

    a_halt_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg && !(take && in_byte.last) |=> halted_reg && phase_reg == $past(phase_reg))
        else $error("halted parser changed state");

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> !res_valid)
        else $error("result while halted");

    a_imbalance_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        take && res_valid && res.status == STATUS_IMBALANCE |->
            res.kind == KIND_END_COLLECTION && res.nest_depth == 8'd0 && halted_next == !in_byte.last)
        else $error("bad imbalance result");

endmodule

[tb/hid_report_descriptor_parser_tb.sv]
// testbench for the hid report descriptor parser: byte stream in, item results out,
// checked against an in-bench parse model held in a small scoreboard class
// depends on hrd_pkg and hid_report_descriptor_parser

`timescale 1ns / 100ps

module hid_report_descriptor_parser_tb;
    import hrd_pkg::*;

    localparam int unsigned RANDOM_BYTES = 800;
    localparam int unsigned DEEP_NEST    = 260;
    localparam int unsigned TIMEOUT_NS   = 5_000_000;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tlast  = 1'b0;
    logic         m_tready = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic [287:0] m_tdata;
    logic [2:0]   m_tuser;

    hid_report_descriptor_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    class descriptor_scoreboard;
        logic [2:0]  phase;
        logic [7:0]  prefix;
        logic [31:0] acc;
        logic [31:0] page;
        logic [31:0] lmin;
        logic [31:0] lmax;
        logic [31:0] rsize;
        logic [31:0] rcount;
        logic [31:0] rid;
        logic [31:0] range_lo;
        logic [31:0] first_use;
        logic [15:0] use_cnt;
        logic [7:0]  depth;
        bit          halted;

        hrd_result_t pending_items[$];
        int unsigned fail_count;
        int unsigned match_count;

        function new();
            clear_state();
            fail_count  = 0;
            match_count = 0;
        endfunction

        function void clear_state();
            phase     = '0;
            prefix    = '0;
            acc       = '0;
            page      = '0;
            lmin      = '0;
            lmax      = '0;
            rsize     = '0;
            rcount    = '0;
            rid       = '0;
            range_lo  = '0;
            first_use = '0;
            use_cnt   = '0;
            depth     = '0;
            halted    = 1'b0;
        endfunction

        function void record(hrd_kind_t kind, logic [31:0] val, hrd_status_t st);
            hrd_result_t r;
            r.kind         = kind;
            r.item_value   = val;
            r.usage_page   = page;
            r.logical_min  = lmin;
            r.logical_max  = lmax;
            r.report_size  = rsize;
            r.report_count = rcount;
            r.report_id    = rid;
            r.first_usage  = first_use;
            r.usage_count  = use_cnt;
            r.nest_depth   = depth;
            r.status       = st;
            pending_items.push_back(r);
        endfunction

        function void add_usages(logic [31:0] first, logic [63:0] n);
            logic [63:0] total;
            if (n == 0) return;
            if (use_cnt == 0) first_use = first;
            total = {48'b0, use_cnt} + n;
            use_cnt = (total > {48'b0, COUNT_MAX}) ? COUNT_MAX : total[15:0];
        endfunction

        function int unsigned payload_len(logic [1:0] code);
            return (code == SIZE_FOUR) ? 4 : code;
        endfunction

        function bit finish_item(logic [7:0] pfx, logic [31:0] val);
            logic [31:0] uval;
            bit          emits;
            hrd_kind_t   kind;
            uval  = (pfx[1:0] != SIZE_FOUR) ? (val | page) : val;
            emits = 1'b0;
            kind  = KIND_INPUT;
            case (pfx & TAG_MASK)
                ITEM_INPUT: begin
                    kind  = KIND_INPUT;
                    emits = 1'b1;
                end
                ITEM_OUTPUT: begin
                    kind  = KIND_OUTPUT;
                    emits = 1'b1;
                end
                ITEM_FEATURE: begin
                    kind  = KIND_FEATURE;
                    emits = 1'b1;
                end
                ITEM_COLLECTION: begin
                    if (depth != DEPTH_MAX) depth++;
                    kind  = KIND_COLLECTION;
                    emits = 1'b1;
                end
                ITEM_END_COLL: begin
                    if (depth == 0) begin
                        record(KIND_END_COLLECTION, val, STATUS_IMBALANCE);
                        halted = 1'b1;
                        return 1'b1;
                    end
                    depth--;
                    kind  = KIND_END_COLLECTION;
                    emits = 1'b1;
                end
                ITEM_USAGE_PAGE:   page   = val << 16;
                ITEM_LOGICAL_MIN:  lmin   = val;
                ITEM_LOGICAL_MAX:  lmax   = val;
                ITEM_REPORT_SIZE:  rsize  = val;
                ITEM_REPORT_ID:    rid    = val;
                ITEM_REPORT_COUNT: rcount = val;
                ITEM_USAGE:        add_usages(uval, 64'd1);
                ITEM_USAGE_MIN:    range_lo = uval;
                ITEM_USAGE_MAX: begin
                    if (uval >= range_lo)
                        add_usages(range_lo, {32'b0, uval} - {32'b0, range_lo} + 64'd1);
                end
                default: ;
            endcase
            if (emits) begin
                record(kind, val, STATUS_OK);
                first_use = '0;
                use_cnt   = '0;
                range_lo  = '0;
            end
            return emits;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            bit         emitted;
            logic [1:0] idx;
            emitted = 1'b0;
            if (!halted) begin
                if (phase == 0) begin
                    if (b[1:0] == SIZE_NONE) begin
                        emitted = finish_item(b, 32'd0);
                    end else begin
                        prefix = b;
                        acc    = '0;
                        phase  = 3'd1;
                    end
                end else begin
                    idx = 2'(phase - 3'd1);
                    acc = acc | ({24'b0, b} << (8 * idx));
                    if (phase >= payload_len(prefix[1:0])) begin
                        phase   = '0;
                        emitted = finish_item(prefix, acc);
                    end else begin
                        phase++;
                    end
                end
                if (last && phase != 0 && !emitted)
                    record(KIND_INPUT, 32'd0, STATUS_TRUNCATED);
            end
            if (last) clear_state();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(logic [2:0] kind, logic [287:0] data);
            hrd_result_t want;
            int unsigned prior_fails;
            if (pending_items.size() == 0) begin
                $display("%0t ns: result expected none actual kind %0d data %h",
                         $time, kind, data);
                fail_count++;
                return;
            end
            want        = pending_items.pop_front();
            prior_fails = fail_count;
            compare_field("item_kind",    {29'b0, want.kind},       {29'b0, kind});
            compare_field("item_value",   want.item_value,          data[31:0]);
            compare_field("usage_page",   want.usage_page,          data[63:32]);
            compare_field("logical_min",  want.logical_min,         data[95:64]);
            compare_field("logical_max",  want.logical_max,         data[127:96]);
            compare_field("report_size",  want.report_size,         data[159:128]);
            compare_field("report_count", want.report_count,        data[191:160]);
            compare_field("report_id",    want.report_id,           data[223:192]);
            compare_field("first_usage",  want.first_usage,         data[255:224]);
            compare_field("usage_count",  {16'b0, want.usage_count}, {16'b0, data[271:256]});
            compare_field("nest_depth",   {24'b0, want.nest_depth},  {24'b0, data[279:272]});
            compare_field("status",       {30'b0, want.status},      {30'b0, data[281:280]});
            if (fail_count == prior_fails) match_count++;
        endfunction
    endclass

    descriptor_scoreboard sb;
    logic [7:0]  desc_q[$];
    int unsigned bytes_sent  = 0;
    int unsigned descriptors = 0;
    int unsigned burst_left  = 0;
    bit          steady      = 1'b0;
    bit          rx_on       = 1'b0;
    int unsigned rx_run      = 0;

    // receiver stall pattern
    always @(posedge aclk) begin
        if (rx_run == 0) begin
            rx_on  = ~rx_on;
            rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 7);
        end else begin
            rx_run--;
        end
        m_tready <= rx_on | steady;
    end

    // outputs are stable at the falling edge; a transfer there lands on the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    function automatic void put_item(input logic [7:0] tag, input logic [1:0] code,
                                     input logic [31:0] value, input int unsigned keep = 4);
        int unsigned len;
        len = (code == SIZE_FOUR) ? 4 : code;
        desc_q.push_back(tag | {6'b0, code});
        for (int unsigned k = 0; k < len && k < keep; k++) desc_q.push_back(value[8*k +: 8]);
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic l);
        int unsigned gap;
        bit          taken;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do begin
            @(negedge aclk);
            taken = s_tready;
            if (taken) sb.note_byte(d, l);
            @(posedge aclk);
        end while (!taken);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_descriptor();
        for (int i = 0; i < desc_q.size(); i++) send_byte(desc_q[i], i == desc_q.size() - 1);
        desc_q.delete();
        descriptors++;
    endtask

    task automatic build_random_descriptor();
        int unsigned n_items;
        int unsigned nest;
        bit          noise;
        logic [1:0]  code;
        logic [7:0]  tag;
        n_items = $urandom_range(1, 24);
        nest    = 0;
        noise   = ($urandom_range(0, 9) == 0);
        for (int unsigned i = 0; i < n_items; i++) begin
            code = 2'($urandom_range(0, 3));
            if (noise) begin
                desc_q.push_back(8'($urandom_range(0, 255)));
                continue;
            end
            case ($urandom_range(0, 19))
                0: tag = ITEM_INPUT;
                1: tag = ITEM_OUTPUT;
                2: tag = ITEM_FEATURE;
                3, 4: begin
                    tag = ITEM_COLLECTION;
                    nest++;
                end
                5, 6: begin
                    // mostly balanced, now and then an end at depth zero
                    if (nest > 0) begin
                        tag = ITEM_END_COLL;
                        nest--;
                    end else begin
                        tag = ($urandom_range(0, 3) == 0) ? ITEM_END_COLL : ITEM_USAGE;
                    end
                end
                7:  tag = ITEM_USAGE_PAGE;
                8:  tag = ITEM_LOGICAL_MIN;
                9:  tag = ITEM_LOGICAL_MAX;
                10: tag = ITEM_REPORT_SIZE;
                11: tag = ITEM_REPORT_ID;
                12: tag = ITEM_REPORT_COUNT;
                13, 14: tag = ITEM_USAGE;
                15: tag = ITEM_USAGE_MIN;
                16: tag = ITEM_USAGE_MAX;
                default: tag = {6'($urandom_range(0, 63)), 2'b00};
            endcase
            put_item(tag, code, random_value());
        end
        // item cut short by the final byte
        if ($urandom_range(0, 5) == 0) begin
            code = 2'($urandom_range(1, 3));
            put_item({6'($urandom_range(0, 63)), 2'b00}, code, random_value(),
                     $urandom_range(0, ((code == SIZE_FOUR) ? 4 : code) - 1));
        end
    endtask

    initial begin
        int unsigned directed_bytes;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: globals, locals, every main item, unbalanced end, halt, truncation
        put_item(ITEM_USAGE_PAGE,   2'd1,      32'h1);
        put_item(ITEM_USAGE,        2'd1,      32'h2);
        put_item(ITEM_COLLECTION,   2'd1,      32'h1);
        put_item(ITEM_USAGE_MIN,    2'd1,      32'h1);
        put_item(ITEM_USAGE_MAX,    2'd1,      32'h3);
        put_item(ITEM_LOGICAL_MIN,  SIZE_FOUR, 32'hFFFF_FFFF);
        put_item(ITEM_LOGICAL_MAX,  2'd2,      32'h7FFF);
        put_item(ITEM_OUTPUT,       SIZE_NONE, 32'h0);
        put_item(ITEM_INPUT,        2'd1,      32'h2);
        put_item(ITEM_FEATURE,      SIZE_NONE, 32'h0);
        put_item(ITEM_END_COLL,     SIZE_NONE, 32'h0);
        put_item(ITEM_END_COLL,     SIZE_NONE, 32'h0);
        put_item(ITEM_OUTPUT,       SIZE_NONE, 32'h0);
        send_descriptor();
        put_item(ITEM_REPORT_ID,    2'd2,      32'h0102, 1);
        send_descriptor();
        directed_bytes = bytes_sent;

        while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
            steady = ($urandom_range(0, 4) == 0);
            if (descriptors == 10) begin
                // saturate the usage count and the nesting depth
                put_item(ITEM_USAGE_MIN, SIZE_FOUR, 32'h0);
                put_item(ITEM_USAGE_MAX, SIZE_FOUR, 32'hFFFF_FFFF);
                for (int unsigned i = 0; i < DEEP_NEST; i++)
                    put_item(ITEM_COLLECTION, SIZE_NONE, 32'h0);
                repeat (3) put_item(ITEM_END_COLL, SIZE_NONE, 32'h0);
            end else begin
                build_random_descriptor();
            end
            send_descriptor();
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        while (sb.pending_items.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("ran %0d descriptors, %0d bytes, %0d results matched", descriptors,
                 bytes_sent, sb.match_count);
        $display("with nesting, usage ranges, unbalanced ends, halts and cut-short items");
        if (sb.fail_count == 0 && sb.pending_items.size() == 0) begin
            $display("hid_report_descriptor_parser: match");
        end else begin
            $display("hid_report_descriptor_parser: mismatch");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout at %0t ns", $time);
        $display("hid_report_descriptor_parser: mismatch");
        $finish;
    end

endmodule
